### hdl/tmed_pkg.sv
// tmed_pkg: shared types for the trimmed median core
// holds the control bundle that the top level broadcasts to the sorting cells
// no dependencies
package tmed_pkg;

	// per-cycle control broadcast along the cell row
	typedef struct packed {
		logic ins;   // place the broadcast sample into the sorted row
		logic shl;   // move every cell one place toward cell zero
	} cell_ctrl_t;

endpackage

### hdl/trimmed_median_core.sv
// trimmed_median_core: streamed trimmed median over a sorted row of cells
// depends on tmed_pkg and tmed_cell
// one insertion-sort cell per store entry, then a drain shift to bring the middle to cell zero
//
// Samples of a set enter one per cycle on start while busy is low; each cycle the whole row of
// MAX_SAMPLES cells places the new sample in ascending order. Samples past MAX_SAMPLES are dropped
// and reported through overflow. An item with last set closes the set: busy goes high and the row
// shifts toward cell zero once a cycle until the middle entry sits in cell zero (the middle pair
// in cells zero and one for an even count), then registers the result. The result (twice the
// median of the set with one smallest and one largest sample set aside when more than two were
// held) appears for one cycle with done high; it cannot be held off, so the receiver must take
// it then. busy falls with done, so a new set may start that cycle.
module trimmed_median_core import tmed_pkg::*; #(
	parameter int MAX_SAMPLES = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                       last,
	output logic                       done,
	output logic signed [SAMPLE_BITS:0] median_x2,
	output logic                       valid_res,
	output logic                       overflow
);

	localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
	localparam int SECOND_IDX = (MAX_SAMPLES > 1) ? 1 : 0;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                 state_q;
	logic [CNT_W-1:0]     count_q;
	logic                 overflow_seen_q;
	logic [CNT_W-1:0]     shifts_q;
	logic                 odd_q;
	logic                 valid_q;

	logic                 accept;
	logic                 full;
	logic [CNT_W-1:0]     cnt_next;
	logic [CNT_W:0]       n_ext;
	logic                 trim;
	logic [CNT_W:0]       kept;
	logic [CNT_W:0]       mid;
	logic [CNT_W:0]       shf;
	cell_ctrl_t           ctrl;

	logic signed [SAMPLE_BITS-1:0] cell_val [MAX_SAMPLES];
	logic                          cell_gt  [MAX_SAMPLES];

	assign busy   = (state_q == ST_DRAIN);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(MAX_SAMPLES));

	assign ctrl = '{ins: accept && !full, shl: (state_q == ST_DRAIN) && (shifts_q != '0)};

	// median position from the count as it stands after this item
	always_comb begin
		cnt_next = full ? count_q : count_q + CNT_W'(1);
		n_ext    = {1'b0, cnt_next};
		trim     = (n_ext > (CNT_W+1)'(2));
		kept     = trim ? n_ext - (CNT_W+1)'(2) : n_ext;
		mid      = (CNT_W+1)'(trim) + (kept >> 1);
		if (kept == '0) begin
			shf = '0;
		end else if (kept[0]) begin
			shf = mid;
		end else begin
			shf = mid - (CNT_W+1)'(1);
		end
	end

	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] lv;
		logic                          lg;
		logic signed [SAMPLE_BITS-1:0] rv;

		if (i == 0) begin : g_first
			assign lv = sample;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = cell_val[i-1];
			assign lg = cell_gt[i-1];
		end

		if (i == MAX_SAMPLES - 1) begin : g_end
			assign rv = cell_val[i];
		end else begin : g_inner
			assign rv = cell_val[i+1];
		end

		tmed_cell #(
			.W (SAMPLE_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.sample    (sample),
			.occupied  (count_q > CNT_W'(i)),
			.tail      (count_q == CNT_W'(i)),
			.left_val  (lv),
			.left_gt   (lg),
			.right_val (rv),
			.val       (cell_val[i]),
			.gt        (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			count_q         <= '0;
			overflow_seen_q <= 1'b0;
			shifts_q        <= '0;
			odd_q           <= 1'b0;
			valid_q         <= 1'b0;
			done            <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= cnt_next;
						if (full) begin
							overflow_seen_q <= 1'b1;
						end
						if (last) begin
							shifts_q <= shf[CNT_W-1:0];
							odd_q    <= kept[0];
							valid_q  <= (kept != '0);
							state_q  <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (shifts_q != '0) begin
						shifts_q <= shifts_q - CNT_W'(1);
					end else begin
						done            <= 1'b1;
						count_q         <= '0;
						overflow_seen_q <= 1'b0;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, loaded with the strobe
	always_ff @(posedge clk) begin
		if ((state_q == ST_DRAIN) && (shifts_q == '0)) begin
			valid_res <= valid_q;
			overflow  <= overflow_seen_q;
			if (!valid_q) begin
				median_x2 <= '0;
			end else if (odd_q) begin
				median_x2 <= {cell_val[0], 1'b0};
			end else begin
				median_x2 <= {cell_val[0][SAMPLE_BITS-1], cell_val[0]}
					+ {cell_val[SECOND_IDX][SAMPLE_BITS-1], cell_val[SECOND_IDX]};
			end
		end
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond store depth");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (count_q == '0) && !overflow_seen_q && !busy)
		else $error("set not cleared with its result");

	a_drain_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !ctrl.ins)
		else $error("insert during drain");

endmodule

### hdl/tmed_cell.sv
// tmed_cell: one place of the insertion-sort row of the trimmed median core
// depends on tmed_pkg for the control bundle
// holds one sample and hands it to the right neighbor on insert or takes the right one on drain
module tmed_cell import tmed_pkg::*; #(
	parameter int W = 24
) (
	input  logic                clk,
	input  cell_ctrl_t          ctrl,
	input  logic signed [W-1:0] sample,
	input  logic                occupied,
	input  logic                tail,
	input  logic signed [W-1:0] left_val,
	input  logic                left_gt,
	input  logic signed [W-1:0] right_val,
	output logic signed [W-1:0] val,
	output logic                gt
);

	logic signed [W-1:0] val_q;

	// held entry is strictly larger than the new sample, so it moves right
	assign gt  = occupied && (val_q > sample);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.shl) begin
			val_q <= right_val;
		end else if (ctrl.ins && (gt || tail)) begin
			val_q <= left_gt ? left_val : sample;
		end
	end

endmodule

### bench/testbench.sv
// testbench: self-checking bench for trimmed_median_core
// depends on tmed_pkg and the trimmed_median_core rtl; needs no files or arguments
// sets go in at most one item per cycle; a tracker predicts the doubled trimmed median per set
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int SBITS = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 300;
	localparam logic signed [SBITS-1:0] SMAX = {1'b0, {(SBITS-1){1'b1}}};
	localparam logic signed [SBITS-1:0] SMIN = {1'b1, {(SBITS-1){1'b0}}};

	typedef struct {
		logic signed [SBITS:0] median_x2;
		logic                  valid_res;
		logic                  overflow;
	} median_t;

	// keeps the running sorted set and the medians still owed by the core
	class median_tracker;
		logic signed [SBITS-1:0] row[DEPTH];
		int      held;
		bit      dropped;
		median_t owed_q[$];
		int      errors;

		function void take_sample(logic signed [SBITS-1:0] s, logic l);
			int      pos;
			int      first;
			int      kept;
			int      mid;
			longint  twice;
			median_t m;
			if (held >= DEPTH) begin
				dropped = 1'b1;
			end else begin
				pos = held;
				while (pos > 0 && row[pos-1] > s) begin
					row[pos] = row[pos-1];
					pos--;
				end
				row[pos] = s;
				held++;
			end
			if (!l)
				return;
			first = 0;
			kept = held;
			twice = 0;
			if (kept > 2) begin
				first = 1;
				kept -= 2;
			end
			m.valid_res = (kept > 0);
			if (kept > 0) begin
				mid = first + kept / 2;
				if (kept % 2)
					twice = 2 * longint'(row[mid]);
				else
					twice = longint'(row[mid-1]) + longint'(row[mid]);
			end
			m.median_x2 = twice[SBITS:0];
			m.overflow = dropped;
			owed_q.push_back(m);
			held = 0;
			dropped = 1'b0;
		endfunction

		function void check_median(logic signed [SBITS:0] med, logic v, logic o);
			median_t m;
			if (owed_q.size() == 0) begin
				$display("%0t: result with none expected: median_x2 %0d valid_res %b overflow %b",
					$time, med, v, o);
				errors++;
				return;
			end
			m = owed_q.pop_front();
			if (med !== m.median_x2) begin
				$display("%0t: median_x2 expected %0d actual %0d", $time, m.median_x2, med);
				errors++;
			end
			if (v !== m.valid_res) begin
				$display("%0t: valid_res expected %b actual %b", $time, m.valid_res, v);
				errors++;
			end
			if (o !== m.overflow) begin
				$display("%0t: overflow expected %b actual %b", $time, m.overflow, o);
				errors++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [SBITS-1:0] sample = '0;
	logic last = 1'b0;
	logic busy;
	logic done;
	logic signed [SBITS:0] median_x2;
	logic valid_res;
	logic overflow;

	median_tracker tracker = new();
	int items_sent = 0;
	int cycles = 0;

	trimmed_median_core #(
		.MAX_SAMPLES(DEPTH),
		.SAMPLE_BITS(SBITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.sample   (sample),
		.last     (last),
		.done     (done),
		.median_x2(median_x2),
		.valid_res(valid_res),
		.overflow (overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// results are checked before the item of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_median(median_x2, valid_res, overflow);
			if (start && !busy)
				tracker.take_sample(sample, last);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_item(input logic signed [SBITS-1:0] s, input logic l, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			// noise on the data lines while start is low
			start <= 1'b0;
			sample <= SBITS'($urandom);
			last <= 1'($urandom_range(1));
			@(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		last <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_set(input logic signed [SBITS-1:0] vals[$], input int idle_pct);
		foreach (vals[i])
			send_item(vals[i], i == vals.size() - 1, idle_pct);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_set(input int idle_pct);
		int n;
		int r;
		logic signed [SBITS-1:0] s;
		logic signed [SBITS-1:0] prev;
		r = $urandom_range(99);
		if (r < 80)
			n = $urandom_range(10, 1);
		else if (r < 92)
			n = $urandom_range(DEPTH, 11);
		else
			n = $urandom_range(DEPTH + 4, DEPTH - 2);  // around a full store
		prev = '0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 70)
				s = SBITS'($urandom);
			else if (r < 80)
				s = $urandom_range(1) ? SMAX : SMIN;
			else if (r < 90)
				s = SBITS'($signed($urandom_range(8)) - 4);  // small values, many ties
			else
				s = prev;
			prev = s;
			send_item(s, i == n - 1, idle_pct);
		end
	endtask

	initial begin
		logic signed [SBITS-1:0] vals[$];
		int target;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets: one, two, three, even and odd counts, extremes
		vals = '{SMAX};                 send_set(vals, 8);
		vals = '{SMIN};                 send_set(vals, 8);
		vals = '{SMAX, SMAX};           send_set(vals, 8);
		vals = '{SMIN, SMIN};           send_set(vals, 8);
		vals = '{SMAX, SMIN};           send_set(vals, 8);
		vals = '{0, -1, 1};             send_set(vals, 8);
		vals = '{5, 1, 3, 2};           send_set(vals, 8);
		vals = '{SMAX, SMIN, 7, 7, -3}; send_set(vals, 8);
		wait_drained();

		target = items_sent + ITEMS_PER_PHASE;
		while (items_sent < target)
			random_set(8);
		wait_drained();
		target = items_sent + ITEMS_PER_PHASE;
		while (items_sent < target)
			random_set(68);
		wait_drained();
		target = items_sent + ITEMS_PER_PHASE;
		while (items_sent < target)
			random_set(0);

		wait_drained();
		repeat (40) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
